// ===== sv/rpn_calc_pkg.sv =====
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared widths, command codes, result kinds and the queue word layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpn_calc_pkg;

  // Fixed-point format of stack values.
  localparam int VAL_W       = 48;
  localparam int FRAC_BITS   = 16;
  localparam int FRAC_DIGITS = 5;

  // Literal accumulators.
  localparam int INT_W   = VAL_W;
  localparam int FRAC_W  = (FRAC_DIGITS > 0) ? $clog2(10 ** FRAC_DIGITS) : 1;
  localparam int DIG_W   = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
  localparam int SCALE_W = 30;

  // Divider geometry: dividend holds a value shifted up by the fraction bits.
  localparam int DIV_NW = VAL_W + FRAC_BITS;
  localparam int DIV_DW = VAL_W;

  // Defaults for top-level parameters.
  localparam int STACK_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH     = 4;

  // Result kinds.
  localparam logic [2:0] KIND_VALUE     = 3'd0;
  localparam logic [2:0] KIND_DIV_ZERO  = 3'd1;
  localparam logic [2:0] KIND_BAD_MOD   = 3'd2;
  localparam logic [2:0] KIND_UNKNOWN   = 3'd3;
  localparam logic [2:0] KIND_EMPTY     = 3'd4;
  localparam logic [2:0] KIND_FULL      = 3'd5;

  // Commands passed from the parser to the execution side.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_NUM,
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV,
    CMD_MOD,
    CMD_POP,
    CMD_BAD
  } cmd_t;

  // One queue word: up to two commands caused by one character.
  // The number fields belong to the first command when it is CMD_NUM.
  typedef struct packed {
    cmd_t              cmd1;
    cmd_t              cmd2;
    logic              neg;
    logic [INT_W-1:0]  int_acc;
    logic [FRAC_W-1:0] frac_acc;
    logic [DIG_W-1:0]  digits;
  } q_word_t;

  // Parser modes.
  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SIGN,
    MODE_INT,
    MODE_FRAC
  } mode_t;

  // Execution sequencer states.
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DISPATCH,
    BK_POPB,
    BK_GETB,
    BK_POPA,
    BK_GETA,
    BK_EXEC,
    BK_MUL,
    BK_MULEND,
    BK_DIV,
    BK_PUSH,
    BK_OUT
  } back_state_t;

endpackage

// ===== sv/rpn_character_calculator.sv =====
// ----------------------------------------------------------------------------
// RPN character calculator
// Evaluates reverse Polish expressions fed one ASCII character per word.
// ----------------------------------------------------------------------------
// The front end takes one character word per cycle while its four-word
// command queue has room, and classifies it at once. The execution side
// drains the queue one character at a time. Multiply sums four half-width
// partial products, and divide and modulus run the bit-serial divider,
// one quotient bit per dividend bit (48 plus fraction bits), before the
// result is handed over. A number with a fraction also goes through the
// divider once. Each result word is then held on the output until it is
// taken. Values are signed Q31.16; the value stack is a memory with a
// registered read port, so every pop has a pop state and a read state.
`timescale 1ns / 1ps

module rpn_character_calculator #(
  parameter int STACK_DEPTH = rpn_calc_pkg::STACK_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            in_ch,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            out_kind,
  output logic signed [rpn_calc_pkg::VAL_W-1:0] out_value,
  output logic                                  out_last
);

  rpn_calc_pkg::q_word_t q_wdata;
  rpn_calc_pkg::q_word_t q_rdata;
  logic                  q_wr;
  logic                  q_full;
  logic                  q_rd;
  logic                  q_avail;

  // Character parser.
  rpn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ch    (in_ch),
    .q_wr     (q_wr),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  // Command queue.
  rpn_fifo #(
    .DEPTH (rpn_calc_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .avail (q_avail),
    .rdata (q_rdata)
  );

  // Stack machine and result delivery.
  rpn_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_avail   (q_avail),
    .q_rd      (q_rd),
    .q_rdata   (q_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule

// ===== sv/rpn_front.sv =====
// ----------------------------------------------------------------------------
// RPN front end
// Accepts characters, tracks number literals and turns each character into
// a queue word of up to two commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_ch,
  output logic                  q_wr,
  output rpn_calc_pkg::q_word_t q_wdata,
  input  logic                  q_full
);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam int IW = rpn_calc_pkg::INT_W;
  localparam int FW = rpn_calc_pkg::FRAC_W;
  localparam int DW = rpn_calc_pkg::DIG_W;
  localparam logic [IW-1:0] INT_CAP = IW'(1) << (47 - rpn_calc_pkg::FRAC_BITS);
  localparam logic [DW-1:0] DIG_MAX = DW'(rpn_calc_pkg::FRAC_DIGITS);

  rpn_calc_pkg::mode_t mode_r, mode_nxt;
  logic                neg_r, neg_nxt;
  logic [IW-1:0]       int_r, int_nxt;
  logic [FW-1:0]       frac_r, frac_nxt;
  logic [DW-1:0]       dig_r, dig_nxt;
  logic                ended_r, ended_nxt;

  logic                accept;
  logic                is_digit;
  logic [3:0]          dval;
  logic [IW+3:0]       int_mac;
  logic [FW+3:0]       frac_mac;
  rpn_calc_pkg::cmd_t  c1, c2;
  logic                act;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_digit = (in_ch >= CH_0) && (in_ch <= CH_9);
  assign dval     = 4'(in_ch - CH_0);

  // Multiply-accumulate by ten for the literal digits.
  assign int_mac  = ((IW+4)'(int_r) << 3) + ((IW+4)'(int_r) << 1) + (IW+4)'(dval);
  assign frac_mac = ((FW+4)'(frac_r) << 3) + ((FW+4)'(frac_r) << 1) + (FW+4)'(dval);

  // Parser: next literal state and commands for this character.
  always_comb begin
    mode_nxt  = mode_r;
    neg_nxt   = neg_r;
    int_nxt   = int_r;
    frac_nxt  = frac_r;
    dig_nxt   = dig_r;
    ended_nxt = ended_r;
    c1        = rpn_calc_pkg::CMD_NONE;
    c2        = rpn_calc_pkg::CMD_NONE;
    act       = 1'b0;
    if (accept && !ended_r) begin
      unique case (mode_r)
        rpn_calc_pkg::MODE_SIGN: begin
          if (is_digit) begin
            mode_nxt = rpn_calc_pkg::MODE_INT;
            int_nxt  = IW'(dval);
          end else begin
            c1       = neg_r ? rpn_calc_pkg::CMD_SUB : rpn_calc_pkg::CMD_ADD;
            mode_nxt = rpn_calc_pkg::MODE_IDLE;
            neg_nxt  = 1'b0;
            act      = 1'b1;
          end
        end
        rpn_calc_pkg::MODE_INT: begin
          if (is_digit) begin
            int_nxt = (int_mac > (IW+4)'(INT_CAP)) ? INT_CAP : int_mac[IW-1:0];
          end else if (in_ch == CH_DOT) begin
            mode_nxt = rpn_calc_pkg::MODE_FRAC;
          end else begin
            c1  = rpn_calc_pkg::CMD_NUM;
            act = 1'b1;
          end
        end
        rpn_calc_pkg::MODE_FRAC: begin
          if (is_digit) begin
            if (dig_r < DIG_MAX) begin
              frac_nxt = frac_mac[FW-1:0];
              dig_nxt  = dig_r + DW'(1);
            end
          end else begin
            c1  = rpn_calc_pkg::CMD_NUM;
            act = 1'b1;
          end
        end
        default: begin
          act = 1'b1;
        end
      endcase

      // The character acts as a token of its own.
      if (act) begin
        if (c1 == rpn_calc_pkg::CMD_NUM) begin
          mode_nxt = rpn_calc_pkg::MODE_IDLE;
          neg_nxt  = 1'b0;
          int_nxt  = '0;
          frac_nxt = '0;
          dig_nxt  = '0;
        end
        priority if (in_ch == CH_SPACE || in_ch == CH_TAB) begin
          c2 = rpn_calc_pkg::CMD_NONE;
        end else if (is_digit) begin
          mode_nxt = rpn_calc_pkg::MODE_INT;
          neg_nxt  = 1'b0;
          int_nxt  = IW'(dval);
        end else if (in_ch == CH_DOT) begin
          mode_nxt = rpn_calc_pkg::MODE_FRAC;
          neg_nxt  = 1'b0;
          int_nxt  = '0;
        end else if (in_ch == CH_PLUS || in_ch == CH_MINUS) begin
          mode_nxt = rpn_calc_pkg::MODE_SIGN;
          neg_nxt  = (in_ch == CH_MINUS);
        end else if (in_ch == CH_STAR) begin
          c2 = rpn_calc_pkg::CMD_MUL;
        end else if (in_ch == CH_SLASH) begin
          c2 = rpn_calc_pkg::CMD_DIV;
        end else if (in_ch == CH_PCT) begin
          c2 = rpn_calc_pkg::CMD_MOD;
        end else if (in_ch == CH_NL) begin
          c2 = rpn_calc_pkg::CMD_POP;
        end else if (in_ch == CH_TILDE) begin
          ended_nxt = 1'b1;
        end else begin
          c2 = rpn_calc_pkg::CMD_BAD;
        end
      end
    end
  end

  // Queue word carries the literal as it stood before this character.
  always_comb begin
    q_wdata.cmd1     = c1;
    q_wdata.cmd2     = c2;
    q_wdata.neg      = neg_r;
    q_wdata.int_acc  = int_r;
    q_wdata.frac_acc = frac_r;
    q_wdata.digits   = dig_r;
    q_wr = (c1 != rpn_calc_pkg::CMD_NONE) || (c2 != rpn_calc_pkg::CMD_NONE);
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= rpn_calc_pkg::MODE_IDLE;
      neg_r   <= 1'b0;
      int_r   <= '0;
      frac_r  <= '0;
      dig_r   <= '0;
      ended_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      neg_r   <= neg_nxt;
      int_r   <= int_nxt;
      frac_r  <= frac_nxt;
      dig_r   <= dig_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

// ===== sv/rpn_fifo.sv =====
// ----------------------------------------------------------------------------
// RPN command queue
// Small first-in first-out queue of command words between the two halves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_fifo #(
  parameter int DEPTH = rpn_calc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr,
  input  rpn_calc_pkg::q_word_t wdata,
  output logic                  full,
  input  logic                  rd,
  output logic                  avail,
  output rpn_calc_pkg::q_word_t rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rpn_calc_pkg::q_word_t mem_r [DEPTH];
  logic [AW-1:0]         wp_r, wp_nxt;
  logic [AW-1:0]         rp_r, rp_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign avail = (cnt_r != '0);
  assign rdata = mem_r[rp_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && avail;

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage words.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== sv/rpn_div.sv =====
// ----------------------------------------------------------------------------
// RPN divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [rpn_calc_pkg::DIV_NW-1:0] dividend,
  input  logic [rpn_calc_pkg::DIV_DW-1:0] divisor,
  output logic                            done,
  output logic [rpn_calc_pkg::DIV_NW-1:0] quotient,
  output logic [rpn_calc_pkg::DIV_DW-1:0] remainder
);

  localparam int NW = rpn_calc_pkg::DIV_NW;
  localparam int DW = rpn_calc_pkg::DIV_DW;
  localparam int SW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dsr_r, dsr_nxt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  // Shift in the next dividend bit and try a subtract.
  assign rem_sh  = {rem_r, quo_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = SW'(NW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = rem_sub[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      step_nxt = step_r - SW'(1);
      if (step_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

// ===== sv/rpn_back.sv =====
// ----------------------------------------------------------------------------
// RPN execution side
// Runs queued commands against the value stack and delivers result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_back #(
  parameter int STACK_DEPTH = rpn_calc_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_avail,
  output logic                        q_rd,
  input  rpn_calc_pkg::q_word_t       q_rdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_kind,
  output logic signed [rpn_calc_pkg::VAL_W-1:0] out_value,
  output logic                        out_last
);

  localparam int VW   = rpn_calc_pkg::VAL_W;
  localparam int FB   = rpn_calc_pkg::FRAC_BITS;
  localparam int NW   = rpn_calc_pkg::DIV_NW;
  localparam int HW   = VW / 2;
  localparam int MAGW = 2 * VW;
  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int SCW  = rpn_calc_pkg::SCALE_W;
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] ONE     = VW'(1) << FB;

  // Powers of ten for fraction scaling.
  function automatic logic [SCW-1:0] pow10(input logic [rpn_calc_pkg::DIG_W-1:0] d);
    logic [SCW-1:0] p;
    unique case (4'(d))
      4'd0:    p = SCW'(1);
      4'd1:    p = SCW'(10);
      4'd2:    p = SCW'(100);
      4'd3:    p = SCW'(1000);
      4'd4:    p = SCW'(10000);
      4'd5:    p = SCW'(100000);
      4'd6:    p = SCW'(1000000);
      4'd7:    p = SCW'(10000000);
      4'd8:    p = SCW'(100000000);
      4'd9:    p = SCW'(1000000000);
      default: p = SCW'(1);
    endcase
    return p;
  endfunction

  // Magnitude of a signed stack value.
  function automatic logic [VW-1:0] mag_of(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  // Apply a sign to a magnitude, saturating to the value range.
  function automatic logic signed [VW-1:0] sat_mag(input logic [MAGW-1:0] m,
                                                   input logic neg);
    logic signed [VW-1:0] r;
    if (neg) begin
      r = (m > MAGW'(VAL_MAX) + MAGW'(1)) ? VAL_MIN : VW'(-m[VW-1:0]);
    end else begin
      r = (m > MAGW'(VAL_MAX)) ? VAL_MAX : m[VW-1:0];
    end
    return r;
  endfunction

  // Stack memory.
  logic signed [VW-1:0] stack_mem [STACK_DEPTH];
  logic signed [VW-1:0] rd_data_r;
  logic [AW-1:0]        mem_raddr;
  logic                 mem_we;
  logic [CW-1:0]        cnt_dec;

  // Sequencer registers.
  rpn_calc_pkg::back_state_t state_r, state_nxt;
  rpn_calc_pkg::q_word_t     ent_r, ent_nxt;
  rpn_calc_pkg::cmd_t        op_r, op_nxt;
  logic                      sel_r, sel_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      empty_r, empty_nxt;
  logic                      aemp_r, aemp_nxt;
  logic signed [VW-1:0]      a_r, a_nxt;
  logic signed [VW-1:0]      b_r, b_nxt;
  logic [VW-1:0]             ma_r, ma_nxt;
  logic [VW-1:0]             mb_r, mb_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [VW-1:0]      push_r, push_nxt;
  logic [MAGW-1:0]           acc_r, acc_nxt;
  logic [1:0]                mstep_r, mstep_nxt;
  logic [1:0]                nres_r, nres_nxt;
  logic                      oidx_r, oidx_nxt;
  logic [2:0]                rkind_r [2];
  logic [2:0]                rkind_nxt [2];
  logic signed [VW-1:0]      rval_r [2];
  logic signed [VW-1:0]      rval_nxt [2];

  // Divider hookup.
  logic                 div_start;
  logic [NW-1:0]        div_dividend;
  logic [VW-1:0]        div_divisor;
  logic                 div_done;
  logic [NW-1:0]        div_quo;
  logic [VW-1:0]        div_rem;

  // Working signals.
  rpn_calc_pkg::cmd_t   cur;
  logic                 emit_en;
  logic [2:0]           emit_kind;
  logic signed [VW-1:0] emit_val;
  logic                 adv;
  logic signed [VW-1:0] opv;
  logic signed [VW:0]   sum;
  logic [SCW-1:0]       scale;
  logic [VW:0]          num_mag;
  logic [VW-1:0]        mod_val;
  logic [VW-1:0]        ub;
  logic [HW-1:0]        mx, my;
  logic [2*HW-1:0]      part;

  rpn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign cur       = sel_r ? ent_r.cmd2 : ent_r.cmd1;
  assign cnt_dec   = cnt_r - CW'(1);
  assign mem_raddr = cnt_dec[AW-1:0];
  assign scale     = pow10(ent_r.digits);
  assign ub        = b_r;

  // Partial product for the current multiply step.
  assign mx   = mstep_r[0] ? ma_r[2*HW-1:HW] : ma_r[HW-1:0];
  assign my   = mstep_r[1] ? mb_r[2*HW-1:HW] : mb_r[HW-1:0];
  assign part = mx * my;

  // Result word outputs.
  assign out_valid = (state_r == rpn_calc_pkg::BK_OUT);
  assign out_kind  = rkind_r[oidx_r];
  assign out_value = rval_r[oidx_r];
  assign out_last  = ({1'b0, oidx_r} == (nres_r - 2'd1));

  // Sequencer: next state, stack updates and result collection.
  always_comb begin
    state_nxt   = state_r;
    ent_nxt     = ent_r;
    op_nxt      = op_r;
    sel_nxt     = sel_r;
    cnt_nxt     = cnt_r;
    empty_nxt   = empty_r;
    aemp_nxt    = aemp_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    ma_nxt      = ma_r;
    mb_nxt      = mb_r;
    neg_nxt     = neg_r;
    push_nxt    = push_r;
    acc_nxt     = acc_r;
    mstep_nxt   = mstep_r;
    nres_nxt    = nres_r;
    oidx_nxt    = oidx_r;
    rkind_nxt   = rkind_r;
    rval_nxt    = rval_r;
    q_rd        = 1'b0;
    mem_we      = 1'b0;
    div_start   = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    emit_en     = 1'b0;
    emit_kind   = rpn_calc_pkg::KIND_VALUE;
    emit_val    = '0;
    adv         = 1'b0;
    opv         = '0;
    sum         = '0;
    num_mag     = '0;
    mod_val     = '0;

    unique case (state_r)
      rpn_calc_pkg::BK_IDLE: begin
        if (q_avail) begin
          q_rd      = 1'b1;
          ent_nxt   = q_rdata;
          sel_nxt   = 1'b0;
          nres_nxt  = '0;
          oidx_nxt  = 1'b0;
          state_nxt = rpn_calc_pkg::BK_DISPATCH;
        end
      end

      rpn_calc_pkg::BK_DISPATCH: begin
        op_nxt    = cur;
        empty_nxt = 1'b0;
        aemp_nxt  = 1'b0;
        unique case (cur)
          rpn_calc_pkg::CMD_NONE: begin
            adv = 1'b1;
          end
          rpn_calc_pkg::CMD_BAD: begin
            emit_en   = 1'b1;
            emit_kind = rpn_calc_pkg::KIND_UNKNOWN;
            adv       = 1'b1;
          end
          rpn_calc_pkg::CMD_NUM: begin
            if (ent_r.digits == '0) begin
              num_mag = (VW+1)'(VW'(ent_r.int_acc << FB));
              opv     = (num_mag > (VW+1)'(VAL_MAX)) ? VAL_MAX : num_mag[VW-1:0];
              push_nxt  = ent_r.neg ? -opv : opv;
              state_nxt = rpn_calc_pkg::BK_PUSH;
            end else begin
              div_start    = 1'b1;
              div_dividend = (NW'(ent_r.frac_acc) << FB) + NW'(scale >> 1);
              div_divisor  = VW'(scale);
              state_nxt    = rpn_calc_pkg::BK_DIV;
            end
          end
          default: begin
            state_nxt = rpn_calc_pkg::BK_POPB;
          end
        endcase
      end

      // Pop the right operand; an empty stack reads as zero.
      rpn_calc_pkg::BK_POPB: begin
        if (cnt_r == '0) begin
          empty_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_dec;
        end
        state_nxt = rpn_calc_pkg::BK_GETB;
      end

      rpn_calc_pkg::BK_GETB: begin
        opv   = empty_r ? '0 : rd_data_r;
        b_nxt = opv;
        priority if (op_r == rpn_calc_pkg::CMD_POP) begin
          emit_en   = 1'b1;
          emit_kind = empty_r ? rpn_calc_pkg::KIND_EMPTY : rpn_calc_pkg::KIND_VALUE;
          emit_val  = opv;
          adv       = 1'b1;
        end else if (op_r == rpn_calc_pkg::CMD_DIV && opv == '0) begin
          emit_en   = 1'b1;
          emit_kind = empty_r ? rpn_calc_pkg::KIND_EMPTY : rpn_calc_pkg::KIND_DIV_ZERO;
          adv       = 1'b1;
        end else if (op_r == rpn_calc_pkg::CMD_MOD && opv < ONE) begin
          emit_en   = 1'b1;
          emit_kind = empty_r ? rpn_calc_pkg::KIND_EMPTY : rpn_calc_pkg::KIND_BAD_MOD;
          adv       = 1'b1;
        end else begin
          state_nxt = rpn_calc_pkg::BK_POPA;
        end
      end

      // Pop the left operand.
      rpn_calc_pkg::BK_POPA: begin
        if (cnt_r == '0) begin
          empty_nxt = 1'b1;
          aemp_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_dec;
        end
        state_nxt = rpn_calc_pkg::BK_GETA;
      end

      rpn_calc_pkg::BK_GETA: begin
        a_nxt     = aemp_r ? '0 : rd_data_r;
        state_nxt = rpn_calc_pkg::BK_EXEC;
      end

      rpn_calc_pkg::BK_EXEC: begin
        ma_nxt  = mag_of(a_r);
        mb_nxt  = mag_of(b_r);
        neg_nxt = a_r[VW-1] ^ b_r[VW-1];
        unique case (op_r)
          rpn_calc_pkg::CMD_ADD, rpn_calc_pkg::CMD_SUB: begin
            if (op_r == rpn_calc_pkg::CMD_ADD) begin
              sum = {a_r[VW-1], a_r} + {b_r[VW-1], b_r};
            end else begin
              sum = {a_r[VW-1], a_r} - {b_r[VW-1], b_r};
            end
            if (sum[VW] != sum[VW-1]) begin
              push_nxt = sum[VW] ? VAL_MIN : VAL_MAX;
            end else begin
              push_nxt = sum[VW-1:0];
            end
            state_nxt = rpn_calc_pkg::BK_PUSH;
          end
          rpn_calc_pkg::CMD_MUL: begin
            acc_nxt   = '0;
            mstep_nxt = '0;
            state_nxt = rpn_calc_pkg::BK_MUL;
          end
          rpn_calc_pkg::CMD_DIV: begin
            div_start    = 1'b1;
            div_dividend = NW'(mag_of(a_r)) << FB;
            div_divisor  = mag_of(b_r);
            state_nxt    = rpn_calc_pkg::BK_DIV;
          end
          rpn_calc_pkg::CMD_MOD: begin
            neg_nxt      = a_r[VW-1];
            div_start    = 1'b1;
            div_dividend = NW'(mag_of(a_r) >> FB);
            div_divisor  = ub >> FB;
            state_nxt    = rpn_calc_pkg::BK_DIV;
          end
          default: begin
            adv = 1'b1;
          end
        endcase
      end

      // Four half-width partial products, one per cycle.
      rpn_calc_pkg::BK_MUL: begin
        acc_nxt   = acc_r + (MAGW'(part) << (HW * (32'(mstep_r[0]) + 32'(mstep_r[1]))));
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd3) begin
          state_nxt = rpn_calc_pkg::BK_MULEND;
        end
      end

      rpn_calc_pkg::BK_MULEND: begin
        push_nxt  = sat_mag(acc_r >> FB, neg_r);
        state_nxt = rpn_calc_pkg::BK_PUSH;
      end

      rpn_calc_pkg::BK_DIV: begin
        if (div_done) begin
          unique case (op_r)
            rpn_calc_pkg::CMD_NUM: begin
              num_mag  = (VW+1)'(VW'(ent_r.int_acc << FB)) + (VW+1)'(div_quo);
              opv      = (num_mag > (VW+1)'(VAL_MAX)) ? VAL_MAX : num_mag[VW-1:0];
              push_nxt = ent_r.neg ? -opv : opv;
            end
            rpn_calc_pkg::CMD_MOD: begin
              mod_val  = div_rem << FB;
              push_nxt = neg_r ? -mod_val : mod_val;
            end
            default: begin
              push_nxt = sat_mag(MAGW'(div_quo), neg_r);
            end
          endcase
          state_nxt = rpn_calc_pkg::BK_PUSH;
        end
      end

      // Push the result; a full stack drops it.
      rpn_calc_pkg::BK_PUSH: begin
        if (cnt_r == CW'(STACK_DEPTH)) begin
          emit_en   = 1'b1;
          emit_kind = rpn_calc_pkg::KIND_FULL;
        end else begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
          if (op_r != rpn_calc_pkg::CMD_NUM && empty_r) begin
            emit_en   = 1'b1;
            emit_kind = rpn_calc_pkg::KIND_EMPTY;
          end
        end
        adv = 1'b1;
      end

      rpn_calc_pkg::BK_OUT: begin
        if (!out_stall) begin
          if (out_last) begin
            state_nxt = rpn_calc_pkg::BK_IDLE;
          end else begin
            oidx_nxt = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = rpn_calc_pkg::BK_IDLE;
      end
    endcase

    // Collect a result word for this character.
    if (emit_en && nres_r != 2'd2) begin
      rkind_nxt[nres_r[0]] = emit_kind;
      rval_nxt[nres_r[0]]  = emit_val;
      nres_nxt             = nres_r + 2'd1;
    end

    // Move on to the second command, then to delivery.
    if (adv) begin
      if (!sel_r) begin
        sel_nxt   = 1'b1;
        state_nxt = rpn_calc_pkg::BK_DISPATCH;
      end else begin
        state_nxt = (nres_nxt != '0) ? rpn_calc_pkg::BK_OUT : rpn_calc_pkg::BK_IDLE;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpn_calc_pkg::BK_IDLE;
      cnt_r   <= '0;
      sel_r   <= 1'b0;
      nres_r  <= '0;
      oidx_r  <= 1'b0;
      mstep_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
      nres_r  <= nres_nxt;
      oidx_r  <= oidx_nxt;
      mstep_r <= mstep_nxt;
    end
  end

  // Operand and result payload registers.
  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    op_r    <= op_nxt;
    empty_r <= empty_nxt;
    aemp_r  <= aemp_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    neg_r   <= neg_nxt;
    push_r  <= push_nxt;
    acc_r   <= acc_nxt;
    rkind_r <= rkind_nxt;
    rval_r  <= rval_nxt;
  end

  // Stack memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[cnt_r[AW-1:0]] <= push_r;
    end
    rd_data_r <= stack_mem[mem_raddr];
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// RPN character calculator testbench
// Feeds character words to the calculator and checks every result word
// against a predictor of the Q31.16 stack machine kept in this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int    DEPTH  = rpn_calc_pkg::STACK_DEPTH_DEF;
  localparam int    WDOG   = 20000;
  localparam int    NRAND  = 900;
  localparam int    NDIR   = 22;
  localparam int    FBITS  = rpn_calc_pkg::FRAC_BITS;
  localparam logic [1:0] PM_IDLE = 2'd0;
  localparam logic [1:0] PM_SIGN = 2'd1;
  localparam logic [1:0] PM_INT  = 2'd2;
  localparam logic [1:0] PM_FRAC = 2'd3;
  localparam logic signed [63:0] VMAX = 64'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0] VMIN = -64'sh8000_0000_0000;
  localparam logic [63:0] INT_CAP = 64'd1 << (47 - FBITS);

  typedef struct {
    logic [2:0]  kind;
    logic [47:0] value;
    logic        last;
  } res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_ch;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [2:0]  out_kind;
  logic signed [47:0] out_value;
  logic        out_last;

  rpn_character_calculator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_ch(in_ch),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_value(out_value), .out_last(out_last)
  );

  // Predictor state.
  logic signed [63:0] calc_stack [DEPTH];
  int                 calc_count;
  logic [1:0]         calc_mode;
  bit                 calc_neg;
  logic [63:0]        calc_int;
  logic [63:0]        calc_frac;
  int                 calc_digits;
  bit                 calc_ended;
  bit                 calc_empty;
  res_t               expected_words[$];
  res_t               word_buf[$];

  int  errors = 0;
  int  dir_errors = 0;
  int  idle_cycles;
  bit  hold_out;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [63:0] mag_of(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] clamp(logic signed [63:0] v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic logic signed [63:0] signed_mag(logic [127:0] m, bit neg);
    if (neg) begin
      if (m > 128'h8000_0000_0000) return VMIN;
      return -$signed({1'b0, m[62:0]});
    end
    if (m > 128'h7FFF_FFFF_FFFF) return VMAX;
    return $signed({1'b0, m[62:0]});
  endfunction

  task automatic add_word(logic [2:0] k, logic signed [63:0] v);
    res_t w;
    if (word_buf.size() >= 2) return;
    w.kind = k; w.value = v[47:0]; w.last = 1'b0;
    word_buf.push_back(w);
  endtask

  task automatic push_val(logic signed [63:0] v);
    if (calc_count >= DEPTH) begin
      add_word(rpn_calc_pkg::KIND_FULL, 0);
      return;
    end
    calc_stack[calc_count] = v;
    calc_count++;
  endtask

  task automatic pop_val(output logic signed [63:0] v);
    if (calc_count == 0) begin
      calc_empty = 1;
      v = 0;
      return;
    end
    calc_count--;
    v = calc_stack[calc_count];
  endtask

  // Executes one arithmetic operator on the stack.
  task automatic run_op(logic [7:0] c);
    logic signed [63:0] a, b;
    logic [127:0] p;
    logic [63:0]  ia, ib, r;
    calc_empty = 0;
    pop_val(b);
    if (c == "/" && b == 0) begin
      add_word(calc_empty ? rpn_calc_pkg::KIND_EMPTY : rpn_calc_pkg::KIND_DIV_ZERO, 0);
      return;
    end
    if (c == "%" && b < (64'sd1 <<< FBITS)) begin
      add_word(calc_empty ? rpn_calc_pkg::KIND_EMPTY : rpn_calc_pkg::KIND_BAD_MOD, 0);
      return;
    end
    pop_val(a);
    case (c)
      "+": push_val(clamp(a + b));
      "-": push_val(clamp(a - b));
      "*": begin
        p = (128'(mag_of(a)) * 128'(mag_of(b))) >> FBITS;
        push_val(signed_mag(p, (a < 0) != (b < 0)));
      end
      "/": begin
        p = (128'(mag_of(a)) << FBITS) / 128'(mag_of(b));
        push_val(signed_mag(p, (a < 0) != (b < 0)));
      end
      default: begin
        ia = mag_of(a) >> FBITS;
        ib = b >> FBITS;
        r = (ia % ib) << FBITS;
        push_val(a < 0 ? -$signed(r) : $signed(r));
      end
    endcase
    if (calc_empty) add_word(rpn_calc_pkg::KIND_EMPTY, 0);
  endtask

  task automatic close_number();
    logic [63:0] scale, frac, m;
    scale = 1;
    frac = 0;
    for (int i = 0; i < calc_digits; i++) scale = scale * 10;
    if (calc_digits > 0) frac = ((calc_frac << FBITS) + scale / 2) / scale;
    m = (calc_int << FBITS) + frac;
    if (m > VMAX) m = VMAX;
    push_val(calc_neg ? -$signed(m) : $signed(m));
    calc_mode = PM_IDLE;
    calc_neg = 0;
    calc_int = 0;
    calc_frac = 0;
    calc_digits = 0;
  endtask

  // Works out the result words that one accepted character causes.
  task automatic predict_char(logic [7:0] c);
    bit dig;
    logic [63:0] dv;
    logic signed [63:0] v;
    word_buf.delete();
    dig = c >= "0" && c <= "9";
    dv = dig ? 64'(c - "0") : 0;
    if (calc_ended) return;
    case (calc_mode)
      PM_SIGN: begin
        if (dig) begin
          calc_mode = PM_INT;
          calc_int = dv;
          return;
        end
        calc_mode = PM_IDLE;
        run_op(calc_neg ? "-" : "+");
        calc_neg = 0;
      end
      PM_INT: begin
        if (dig) begin
          calc_int = calc_int * 10 + dv;
          if (calc_int > INT_CAP) calc_int = INT_CAP;
          return;
        end
        if (c == ".") begin
          calc_mode = PM_FRAC;
          return;
        end
        close_number();
      end
      PM_FRAC: begin
        if (dig) begin
          if (calc_digits < rpn_calc_pkg::FRAC_DIGITS) begin
            calc_frac = calc_frac * 10 + dv;
            calc_digits++;
          end
          return;
        end
        close_number();
      end
      default: ;
    endcase
    if (c == " " || c == "\t") begin
    end else if (dig) begin
      calc_mode = PM_INT; calc_neg = 0; calc_int = dv;
    end else if (c == ".") begin
      calc_mode = PM_FRAC; calc_neg = 0; calc_int = 0;
    end else if (c == "+" || c == "-") begin
      calc_mode = PM_SIGN; calc_neg = (c == "-");
    end else if (c == "*" || c == "/" || c == "%") begin
      run_op(c);
    end else if (c == "\n") begin
      calc_empty = 0;
      pop_val(v);
      if (calc_empty) add_word(rpn_calc_pkg::KIND_EMPTY, 0);
      else add_word(rpn_calc_pkg::KIND_VALUE, v);
    end else if (c == "~") begin
      calc_ended = 1;
    end else begin
      add_word(rpn_calc_pkg::KIND_UNKNOWN, 0);
    end
    if (word_buf.size() > 0) word_buf[word_buf.size() - 1].last = 1'b1;
    foreach (word_buf[i]) expected_words.push_back(word_buf[i]);
  endtask

  // Sends one character word, with a random gap before it when gaps is set. The valid stays
  // up after acceptance; the next gap or stop_input lowers it.
  task automatic send_char(logic [7:0] c, bit gaps);
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(c);
  endtask

  task automatic send_text(string s, bit gaps);
    for (int i = 0; i < s.len(); i++) send_char(s[i], gaps);
  endtask

  // Lowers the input valid and waits for it to take effect.
  task automatic stop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random token: mostly well-formed numbers and operators, some noise.
  function automatic string rand_token();
    string s;
    int n;
    s = "";
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: begin
        if ($urandom_range(0, 3) == 0) s = ($urandom_range(0, 1) != 0) ? "-" : "+";
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 3);
        repeat (n) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        if ($urandom_range(0, 2) == 0) begin
          s = {s, "."};
          repeat ($urandom_range(0, 7)) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        end
      end
      6, 7: s = "+";
      8, 9: s = "-";
      10, 11: s = "*";
      12: s = "/";
      13: s = "%";
      14, 15: s = "\n";
      16: s = "\t";
      17: s = ".";
      default: s = string'(8'($urandom_range(0, 255)));
    endcase
    if (s != "~" && $urandom_range(0, 1) != 0) s = {s, " "};
    return s;
  endfunction

  // Output side: random stalls, and a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n || hold_out) out_stall <= 1'b1;
    else if ($urandom_range(0, 15) == 0) out_stall <= 1'b1;
    else if ($urandom_range(0, 2) == 0) out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Result checking.
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d value=%0d last=%0d",
                 $time, out_kind, out_value, out_last);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_kind !== e.kind || out_value !== e.value || out_last !== e.last) begin
          $display("%0t: mismatch expected kind=%0d value=%0d last=%0d actual kind=%0d value=%0d last=%0d",
                   $time, e.kind, $signed(e.value), e.last, out_kind, out_value, out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || hold_out)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Directed characters and, where obvious, the word they produce.
  typedef struct {
    logic [7:0] ch;
    bit         known;
    logic [2:0] kind;
    logic [47:0] value;
  } dir_row_t;

  dir_row_t dir_table [NDIR] = '{
    '{"\n", 1, rpn_calc_pkg::KIND_EMPTY,    48'd0},
    '{"+",  0, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{" ",  1, rpn_calc_pkg::KIND_EMPTY,    48'd0},
    '{"0",  0, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{" ",  0, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{"/",  1, rpn_calc_pkg::KIND_DIV_ZERO, 48'd0},
    '{".",  0, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{" ",  0, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{"%",  1, rpn_calc_pkg::KIND_BAD_MOD,  48'd0},
    '{"a",  1, rpn_calc_pkg::KIND_UNKNOWN,  48'd0},
    '{8'hFF, 1, rpn_calc_pkg::KIND_UNKNOWN, 48'd0},
    '{8'h00, 1, rpn_calc_pkg::KIND_UNKNOWN, 48'd0},
    '{"9",  0, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{"\t", 0, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{"\n", 1, rpn_calc_pkg::KIND_VALUE,    48'h9_0000},
    '{".",  0, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{"\n", 1, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{"-",  0, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{"7",  0, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{"*",  0, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{"\n", 0, rpn_calc_pkg::KIND_VALUE,    48'd0},
    '{"\n", 0, rpn_calc_pkg::KIND_VALUE,    48'd0}
  };

  initial begin
    string tok;
    int cnt;
    res_t w;
    hold_out = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ch = 8'd0;
    calc_count = 0; calc_mode = PM_IDLE; calc_neg = 0;
    calc_int = 0; calc_frac = 0; calc_digits = 0; calc_ended = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: rows with a typed-in result are cross-checked too.
    foreach (dir_table[i]) begin
      send_char(dir_table[i].ch, 0);
      if (dir_table[i].known) begin
        if (word_buf.size() == 0) begin
          $display("%0t: mismatch expected kind=%0d value=%0d actual no word",
                   $time, dir_table[i].kind, dir_table[i].value);
          dir_errors++;
        end else begin
          w = word_buf[word_buf.size() - 1];
          if (w.kind !== dir_table[i].kind || w.value !== dir_table[i].value) begin
            $display("%0t: mismatch expected kind=%0d value=%0d actual kind=%0d value=%0d",
                     $time, dir_table[i].kind, dir_table[i].value, w.kind, w.value);
            dir_errors++;
          end
        end
      end
    end
    // Extremes: saturating literal, overflowing products, small divisor, signed modulus.
    send_text("99999999999.999999 99999999999 * \n -99999999999 9 * \n", 1);
    send_text("1 0.00001 / \n -7.5 2 % \n 17 -3 % \n", 1);

    // Receiver holds off while the sender keeps going.
    hold_out = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_out = 0;
      end
      send_text("1 2 + \n a b c \n 3 4 * \n \n", 1);
    join

    // Fill the stack past its depth, then drain it.
    for (int i = 0; i < DEPTH + 3; i++) send_text("1 ", 1);
    send_text("\n", 1);
    // Sender pause until all words are in.
    stop_input();
    while (expected_words.size() != 0) @(posedge clk);
    for (int i = 0; i < DEPTH + 2; i++) send_text("\n", 1);

    // Random part: well-formed token streams with some noise.
    cnt = 0;
    while (cnt < NRAND) begin
      tok = rand_token();
      send_text(tok, 1);
      cnt += tok.len();
    end
    send_text(" \n~1 \n", 1);

    stop_input();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && dir_errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/rpn_calc_pkg.sv
sv/rpn_front.sv
sv/rpn_fifo.sv
sv/rpn_div.sv
sv/rpn_back.sv
sv/rpn_character_calculator.sv
sim/testbench.sv
